// ----- hdl/wcs_pkg.sv -----
// Package with shared types and character constants for the comment and whitespace skipper.
package wcs_pkg;

  // Character codes that the scanner looks for.
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;

  // Input commands.
  localparam logic CmdData  = 1'b0;
  localparam logic CmdFlush = 1'b1;

  // Result queue geometry.
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int FillW     = $clog2(FifoDepth + 1);

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_TEXT  = 3'd0,
    MODE_LINE  = 3'd1,
    MODE_BLOCK = 3'd2,
    MODE_STAR  = 3'd3
  } scan_mode_e;

  // One classified byte on its way out.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        kept;
    logic [31:0] line_number;
    logic        last;
  } result_t;

endpackage

// ----- hdl/whitespace_comment_skipper_unit.sv -----
// The results of a byte accepted at an edge are offered right after that same edge when
// the result queue is empty.
// Throughput: one input byte per cycle and, while out_stall_i is low, one result per cycle;
// a data byte that releases a held slash makes two results, so the input stalls while the
// four-entry result queue has fewer than two free slots.
// Reset (asynchronous, active low) returns the scanner to normal text, drops a held
// slash, clears the newline count and empties the result queue.
module whitespace_comment_skipper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        kept_o,
  output logic [31:0] line_number_o,
  output logic        last_o
);

  wcs_pkg::scan_mode_e mode_q, mode_d;
  logic                held_q, held_d;
  logic [31:0]         count_q, count_d;

  wcs_pkg::result_t    fifo_q [wcs_pkg::FifoDepth];
  logic [wcs_pkg::PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [wcs_pkg::FillW-1:0] fill_q, fill_d;

  logic                in_xfer;
  logic                out_xfer;
  logic [1:0]          n_res;
  wcs_pkg::result_t    res0, res1;
  logic                is_nl;
  logic                is_space;
  logic [31:0]         cnt_nl;

  // Handshakes: accept only with room for two results.
  assign in_stall_o  = (fill_q > wcs_pkg::FillW'(wcs_pkg::FifoDepth - 2));
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = (fill_q != '0);
  assign out_xfer    = out_valid_o && !out_stall_i;

  // Character classes and the saturating newline count.
  assign is_nl    = (text_byte_i == wcs_pkg::ChNl);
  assign is_space = text_byte_i inside {wcs_pkg::ChSpace, wcs_pkg::ChTab,
                                        wcs_pkg::ChNl, wcs_pkg::ChCr};
  assign cnt_nl   = (is_nl && (count_q != '1)) ? count_q + 32'd1 : count_q;

  // Scanner next state for the current transfer.
  always_comb begin
    mode_d = mode_q;
    held_d = held_q;
    count_d = count_q;
    if (in_xfer) begin
      if (command_i == wcs_pkg::CmdFlush) begin
        held_d = 1'b0;
        mode_d = wcs_pkg::MODE_TEXT;
      end else begin
        case (mode_q)
          wcs_pkg::MODE_LINE: begin
            count_d = cnt_nl;
            if (is_nl) begin
              mode_d = wcs_pkg::MODE_TEXT;
            end
          end
          wcs_pkg::MODE_BLOCK, wcs_pkg::MODE_STAR: begin
            count_d = cnt_nl;
            if ((mode_q == wcs_pkg::MODE_STAR) && (text_byte_i == wcs_pkg::ChSlash)) begin
              mode_d = wcs_pkg::MODE_TEXT;
            end else if (text_byte_i == wcs_pkg::ChStar) begin
              mode_d = wcs_pkg::MODE_STAR;
            end else begin
              mode_d = wcs_pkg::MODE_BLOCK;
            end
          end
          default: begin
            mode_d = wcs_pkg::MODE_TEXT;
            if (held_q) begin
              held_d = 1'b0;
              if ((text_byte_i == wcs_pkg::ChSlash) || (text_byte_i == wcs_pkg::ChStar)) begin
                mode_d = (text_byte_i == wcs_pkg::ChSlash) ? wcs_pkg::MODE_LINE
                                                           : wcs_pkg::MODE_BLOCK;
              end else begin
                count_d = cnt_nl;
              end
            end else if (text_byte_i == wcs_pkg::ChSlash) begin
              held_d = 1'b1;
            end else begin
              count_d = cnt_nl;
            end
          end
        endcase
      end
    end
  end

  // Scanner outputs: the results of the current transfer.
  always_comb begin
    n_res = 2'd0;
    res0 = '{out_byte: text_byte_i, kept: 1'b0, line_number: cnt_nl, last: 1'b1};
    res1 = '{out_byte: text_byte_i, kept: 1'b0, line_number: cnt_nl, last: 1'b1};
    if (in_xfer) begin
      if (command_i == wcs_pkg::CmdFlush) begin
        if (held_q) begin
          n_res = 2'd1;
          res0 = '{out_byte: wcs_pkg::ChSlash, kept: 1'b1, line_number: count_q, last: 1'b1};
        end
      end else begin
        case (mode_q)
          wcs_pkg::MODE_LINE, wcs_pkg::MODE_BLOCK, wcs_pkg::MODE_STAR: begin
            n_res = 2'd1;
          end
          default: begin
            if (held_q) begin
              n_res = 2'd2;
              if ((text_byte_i == wcs_pkg::ChSlash) || (text_byte_i == wcs_pkg::ChStar)) begin
                // The held slash opens a comment: both bytes are skipped.
                res0 = '{out_byte: wcs_pkg::ChSlash, kept: 1'b0, line_number: count_q,
                         last: 1'b0};
                res1 = '{out_byte: text_byte_i, kept: 1'b0, line_number: count_q,
                         last: 1'b1};
              end else begin
                // The held slash was a plain character.
                res0 = '{out_byte: wcs_pkg::ChSlash, kept: 1'b1, line_number: count_q,
                         last: 1'b0};
                res1 = '{out_byte: text_byte_i, kept: !is_space, line_number: cnt_nl,
                         last: 1'b1};
              end
            end else if (text_byte_i != wcs_pkg::ChSlash) begin
              n_res = 2'd1;
              res0.kept = !is_space;
            end
          end
        endcase
      end
    end
  end

  // Queue fill level after this cycle's pushes and pop.
  assign fill_d = fill_q + wcs_pkg::FillW'(n_res) - wcs_pkg::FillW'(out_xfer);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= wcs_pkg::MODE_TEXT;
      held_q   <= 1'b0;
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      held_q   <= held_d;
      count_q  <= count_d;
      wr_ptr_q <= wr_ptr_q + wcs_pkg::PtrW'(n_res);
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + wcs_pkg::PtrW'(1);
      end
      fill_q   <= fill_d;
    end
  end

  // Result queue storage; up to two entries written per cycle.
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (n_res == 2'd2) begin
      fifo_q[wr_ptr_q + wcs_pkg::PtrW'(1)] <= res1;
    end
  end

  // Head of the queue drives the output.
  assign out_byte_o    = fifo_q[rd_ptr_q].out_byte;
  assign kept_o        = fifo_q[rd_ptr_q].kept;
  assign line_number_o = fifo_q[rd_ptr_q].line_number;
  assign last_o        = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= wcs_pkg::FillW'(wcs_pkg::FifoDepth))
    else $error("result queue overflow");

  // A slash is only held in normal text mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> (mode_q == wcs_pkg::MODE_TEXT))
    else $error("slash held outside text mode");

  // The newline count never goes down.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= $past(count_q))
    else $error("newline count decreased");

  // A flush always leaves the scanner in text mode with nothing held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (command_i == wcs_pkg::CmdFlush)) |=>
      ((mode_q == wcs_pkg::MODE_TEXT) && !held_q))
    else $error("flush did not reset the scanner");
`endif

endmodule

// ----- verif/tb_whitespace_comment_skipper_unit.sv -----
// Self-checking testbench for the comment and whitespace skipper: directed and random text.
`timescale 1ns / 100ps

module tb_whitespace_comment_skipper_unit;

  // One input transfer as the sender presents it.
  typedef struct packed {
    logic       command;
    logic [7:0] text_byte;
  } text_item_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        command_i   = wcs_pkg::CmdData;
  logic [7:0]  text_byte_i = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        kept_o;
  logic [31:0] line_number_o;
  logic        last_o;

  text_item_t        pending_items[$];
  wcs_pkg::result_t  expected_results[$];

  // Scanner state as the checker sees it.
  wcs_pkg::scan_mode_e model_mode     = wcs_pkg::MODE_TEXT;
  logic                model_slash    = 1'b0;
  logic [31:0]         model_newlines = '0;

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int calm_left       = 0;
  int mismatch_count  = 0;
  int items_queued    = 0;

  whitespace_comment_skipper_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .text_byte_i  (text_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .kept_o       (kept_o),
    .line_number_o(line_number_o),
    .last_o       (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit is_blank(logic [7:0] b);
    return b == wcs_pkg::ChSpace || b == wcs_pkg::ChTab ||
           b == wcs_pkg::ChNl || b == wcs_pkg::ChCr;
  endfunction

  // The newline count stops at its maximum.
  function void count_newline(logic [7:0] b);
    if (b == wcs_pkg::ChNl && model_newlines != 32'hFFFF_FFFF) begin
      model_newlines = model_newlines + 32'd1;
    end
  endfunction

  function wcs_pkg::result_t make_result(logic [7:0] b, logic keep);
    wcs_pkg::result_t r;
    r.out_byte    = b;
    r.kept        = keep;
    r.line_number = model_newlines;
    r.last        = 1'b0;
    return r;
  endfunction

  // Classify one accepted transfer and queue the results it should release.
  function void classify_transfer(logic cmd, logic [7:0] b);
    wcs_pkg::result_t made[2];
    int               n;
    n = 0;
    if (cmd == wcs_pkg::CmdFlush) begin
      if (model_slash) begin
        made[n] = make_result(wcs_pkg::ChSlash, 1'b1);
        n++;
      end
      model_slash = 1'b0;
      model_mode  = wcs_pkg::MODE_TEXT;
    end else begin
      case (model_mode)
        wcs_pkg::MODE_LINE: begin
          count_newline(b);
          made[n] = make_result(b, 1'b0);
          n++;
          if (b == wcs_pkg::ChNl) model_mode = wcs_pkg::MODE_TEXT;
        end
        wcs_pkg::MODE_BLOCK, wcs_pkg::MODE_STAR: begin
          count_newline(b);
          made[n] = make_result(b, 1'b0);
          n++;
          if (model_mode == wcs_pkg::MODE_STAR && b == wcs_pkg::ChSlash) begin
            model_mode = wcs_pkg::MODE_TEXT;
          end else if (b == wcs_pkg::ChStar) begin
            model_mode = wcs_pkg::MODE_STAR;
          end else begin
            model_mode = wcs_pkg::MODE_BLOCK;
          end
        end
        default: begin
          model_mode = wcs_pkg::MODE_TEXT;
          if (model_slash) begin
            model_slash = 1'b0;
            if (b == wcs_pkg::ChSlash || b == wcs_pkg::ChStar) begin
              // The held slash opens a comment; both bytes are skipped.
              made[0] = make_result(wcs_pkg::ChSlash, 1'b0);
              made[1] = make_result(b, 1'b0);
              n = 2;
              if (b == wcs_pkg::ChSlash) model_mode = wcs_pkg::MODE_LINE;
              else model_mode = wcs_pkg::MODE_BLOCK;
            end else begin
              made[0] = make_result(wcs_pkg::ChSlash, 1'b1);
              count_newline(b);
              made[1] = make_result(b, !is_blank(b));
              n = 2;
            end
          end else if (b == wcs_pkg::ChSlash) begin
            model_slash = 1'b1;
          end else begin
            count_newline(b);
            made[n] = make_result(b, !is_blank(b));
            n++;
          end
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) made[i].last = 1'b1;
      expected_results.push_back(made[i]);
    end
  endfunction

  // Stretches without any idling on either side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calm_left <= 0;
    end else if (calm_left != 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(0, 63) == 0) begin
      calm_left <= int'($urandom_range(10, 40));
    end
  end

  // Input driver: predicts on each accepted transfer, then presents the next item.
  always @(posedge clk_i or negedge rst_ni) begin : drive_text
    text_item_t item;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      command_i   <= wcs_pkg::CmdData;
      text_byte_i <= 8'h00;
    end else begin
      if (in_valid_i && !in_stall_o) classify_transfer(command_i, text_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 &&
            !(calm_left == 0 && $urandom_range(0, 99) < sender_idle_pct)) begin
          item = pending_items.pop_front();
          in_valid_i  <= 1'b1;
          command_i   <= item.command;
          text_byte_i <= item.text_byte;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= calm_left == 0 && $urandom_range(0, 99) < stall_pct;
    end
  end

  // Result monitor: every transfer is checked against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    wcs_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("Unexpected result: byte %h kept %b line %0d last %b",
                   out_byte_o, kept_o, line_number_o, last_o);
        end
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_byte_o !== want.out_byte || kept_o !== want.kept ||
            line_number_o !== want.line_number || last_o !== want.last) begin
          if (mismatch_count < 10) begin
            $display("Mismatch: expected byte %h kept %b line %0d last %b,",
                     want.out_byte, want.kept, want.line_number, want.last,
                     " got byte %h kept %b line %0d last %b",
                     out_byte_o, kept_o, line_number_o, last_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  task automatic push_item(logic cmd, logic [7:0] b);
    text_item_t item;
    item.command   = cmd;
    item.text_byte = b;
    pending_items.push_back(item);
    items_queued++;
  endtask

  // The sender holds off until every queued transfer is done and all results are back.
  task automatic wait_until_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] token_char();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 126)); while (b == wcs_pkg::ChSlash);
    return b;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return wcs_pkg::ChSpace;
      1: return wcs_pkg::ChTab;
      2: return wcs_pkg::ChCr;
      default: return wcs_pkg::ChNl;
    endcase
  endfunction

  // Mostly well-formed text: tokens, blanks and comments, with some noise.
  task automatic add_random_segment();
    int         pick;
    logic [7:0] b;
    logic       cmd;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      repeat ($urandom_range(1, 6)) push_item(wcs_pkg::CmdData, token_char());
    end else if (pick < 48) begin
      repeat ($urandom_range(1, 4)) push_item(wcs_pkg::CmdData, blank_char());
    end else if (pick < 60) begin
      push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
      push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
      repeat ($urandom_range(0, 8)) begin
        do b = 8'($urandom_range(0, 255)); while (b == wcs_pkg::ChNl);
        push_item(wcs_pkg::CmdData, b);
      end
      push_item(wcs_pkg::CmdData, wcs_pkg::ChNl);
    end else if (pick < 76) begin
      push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
      push_item(wcs_pkg::CmdData, wcs_pkg::ChStar);
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 9))
          0, 1: b = wcs_pkg::ChStar;
          2: b = wcs_pkg::ChNl;
          3: b = wcs_pkg::ChSlash;
          default: b = 8'($urandom_range(0, 255));
        endcase
        push_item(wcs_pkg::CmdData, b);
      end
      repeat ($urandom_range(1, 3)) push_item(wcs_pkg::CmdData, wcs_pkg::ChStar);
      push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
    end else if (pick < 85) begin
      // A lone slash followed by ordinary text or a blank.
      push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
      push_item(wcs_pkg::CmdData, $urandom_range(0, 1) ? token_char() : blank_char());
    end else if (pick < 91) begin
      if ($urandom_range(0, 1)) push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
      push_item(wcs_pkg::CmdFlush, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        cmd = ($urandom_range(0, 7) == 0) ? wcs_pkg::CmdFlush : wcs_pkg::CmdData;
        push_item(cmd, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : run_stimulus
    int target;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: field extremes, blanks, comment openings and closings, flushes.
    push_item(wcs_pkg::CmdData, "A");
    push_item(wcs_pkg::CmdData, 8'h00);
    push_item(wcs_pkg::CmdData, 8'hFF);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChSpace);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChTab);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChCr);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChNl);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
    push_item(wcs_pkg::CmdData, "x");
    push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
    push_item(wcs_pkg::CmdData, "c");
    push_item(wcs_pkg::CmdData, wcs_pkg::ChNl);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChStar);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChStar);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChStar);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
    push_item(wcs_pkg::CmdFlush, 8'hFF);
    push_item(wcs_pkg::CmdFlush, 8'h00);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChSlash);
    push_item(wcs_pkg::CmdData, wcs_pkg::ChStar);
    push_item(wcs_pkg::CmdFlush, 8'h5A);
    wait_until_drained();

    // Random part over the idling phases.
    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk_i);
      sender_idle_pct = (phase == 1) ? 82 : (phase == 3) ? 17 : 0;
      stall_pct       = (phase == 2) ? 82 : (phase == 3) ? 17 : 0;
      target = items_queued + 256;
      while (items_queued < target) add_random_segment();
      wait_until_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/wcs_pkg.sv
hdl/whitespace_comment_skipper_unit.sv
verif/tb_whitespace_comment_skipper_unit.sv
